### hdl/ikc_pkg.sv
// Shared constants, types and helper functions for the image kernel convolution block.
// No dependencies; ikc_mac and image_kernel_convolution_top import this package.
package ikc_pkg;

   localparam int MAX_HALF     = 3;
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_HEIGHT   = 1024;

   localparam int KMAX       = 2 * MAX_HALF + 1;
   localparam int COEF_DEPTH = KMAX * KMAX;
   localparam int LINE_COLS  = (MAX_WIDTH + 2 * MAX_HALF) * MAX_CHANNELS;
   localparam int WIN_DEPTH  = (KMAX - 1) * MAX_CHANNELS + 1;

   localparam int HALF_W = $clog2(MAX_HALF + 1);
   localparam int CHAN_W = $clog2(MAX_CHANNELS + 1);
   localparam int COL_W  = $clog2(LINE_COLS);
   localparam int PCOL_W = COL_W + 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2 * MAX_HALF);
   localparam int AGE_W  = $clog2(WIN_DEPTH);
   localparam int KIDX_W = $clog2(KMAX);

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int CIDX_W   = 6;
   localparam int RESULT_W = 25;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + $clog2(COEF_DEPTH);
   localparam int FRAC_SHIFT = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KERNEL_HALF   = 3'd0,
      REG_CHANNEL_COUNT = 3'd1,
      REG_IMAGE_WIDTH   = 3'd2,
      REG_IMAGE_HEIGHT  = 3'd3
   } reg_index_type;

   typedef enum logic {
      CMD_COEF   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef sample_type [KMAX-1:0]      column_type;
   typedef sample_type [KMAX-2:0]      line_word_type;

   // Kernel shape in use, already clamped to legal values.
   typedef struct packed {
      logic [HALF_W-1:0] half;
      logic [CHAN_W-1:0] chans;
   } shape_type;

   // Per-beat control that rides along the datapath.
   typedef struct packed {
      logic              valid;
      cmd_type           cmd;
      logic              produce;
      logic              last;
      logic [CIDX_W-1:0] coef_index;
      coef_type          coef_value;
   } beat_type;

   // Window age of kernel column j: (2*half - j) * chans.
   function automatic logic [AGE_W-1:0] tap_age(input int j, input shape_type s);
      int a;
      a = (2 * int'(s.half) - j) * int'(s.chans);
      return AGE_W'(a);
   endfunction

   // Row-major coefficient position i*K + j for the kernel in use.
   function automatic logic [CIDX_W-1:0] coef_pos(input int i, input int j, input shape_type s);
      int p;
      p = i * (2 * int'(s.half) + 1) + j;
      return CIDX_W'(p);
   endfunction

endpackage

### hdl/ikc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
module ikc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hdl/ikc_mac.sv
// Window registers, coefficient store, 49 multipliers and a registered adder tree.
// Depends on ikc_pkg; fed one column beat per enabled cycle by the top level.
module ikc_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  ikc_pkg::shape_type                  shape,
   input  ikc_pkg::beat_type                   beat,
   input  ikc_pkg::column_type                 column,
   output logic                                out_valid,
   output logic signed [ikc_pkg::RESULT_W-1:0] out_result,
   output logic                                out_last
);
   import ikc_pkg::*;

   column_type                win_ff [WIN_DEPTH];
   coef_type                  coef_ff [COEF_DEPTH];
   beat_type                  s2_ff, s3_ff, s4_ff;
   logic signed [PROD_W-1:0]  prod_ff [KMAX][KMAX];
   logic signed [PROD_W-1:0]  prod_in [KMAX][KMAX];
   logic signed [ACC_W-1:0]   rsum_ff [KMAX];
   logic signed [ACC_W-1:0]   rsum_in [KMAX];
   logic signed [ACC_W-1:0]   total_in;
   logic signed [ACC_W-1:0]   shifted;
   logic                      valid_ff;
   logic signed [RESULT_W-1:0] result_ff;
   logic                      last_ff;

   // Tap select and multiply; taps outside the kernel in use give zero.
   always_comb begin
      logic [AGE_W-1:0]  age;
      logic [KIDX_W-1:0] qrow;
      logic [CIDX_W-1:0] cp;
      for (int i = 0; i < KMAX; i++) begin
         for (int j = 0; j < KMAX; j++) begin
            age  = tap_age(j, shape);
            qrow = KIDX_W'(2 * int'(shape.half) - i);
            cp   = coef_pos(i, j, shape);
            if (i <= 2 * int'(shape.half) && j <= 2 * int'(shape.half)) begin
               prod_in[i][j] = PROD_W'(win_ff[age][qrow] * coef_ff[cp]);
            end else begin
               prod_in[i][j] = '0;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KMAX; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < KMAX; j++) begin
            rsum_in[i] = rsum_in[i] + ACC_W'(prod_ff[i][j]);
         end
      end
      total_in = '0;
      for (int i = 0; i < KMAX; i++) begin
         total_in = total_in + rsum_ff[i];
      end
      shifted = total_in >>> FRAC_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         // Window column 0 holds the whole vertical column; older columns shift behind it.
         if (beat.valid && beat.cmd == CMD_SAMPLE) begin
            win_ff[0] <= column;
            for (int a = 1; a < WIN_DEPTH; a++) begin
               win_ff[a] <= win_ff[a-1];
            end
         end
         // Coefficient writes land here so earlier samples still see old values.
         if (s2_ff.valid && s2_ff.cmd == CMD_COEF &&
             int'(s2_ff.coef_index) < COEF_DEPTH) begin
            coef_ff[s2_ff.coef_index] <= s2_ff.coef_value;
         end
         prod_ff   <= prod_in;
         rsum_ff   <= rsum_in;
         result_ff <= shifted[RESULT_W-1:0];
         last_ff   <= s4_ff.last;
      end
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (enable) begin
         s2_ff    <= beat;
         // Drop everything but producing samples past the multiply stage.
         s3_ff    <= {s2_ff.valid && s2_ff.cmd == CMD_SAMPLE && s2_ff.produce,
                      s2_ff[$bits(beat_type)-2:0]};
         s4_ff    <= s3_ff;
         valid_ff <= s4_ff.valid;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign out_last   = last_ff;

   a_stage_only_samples: assert property (@(posedge clock) disable iff (reset)
      s3_ff.valid |-> s3_ff.cmd == CMD_SAMPLE && s3_ff.produce)
      else $error("non-producing beat passed the multiply stage");
   a_out_from_s4: assert property (@(posedge clock) disable iff (reset)
      (enable && !s4_ff.valid) |=> !out_valid)
      else $error("result appeared without a beat behind it");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!enable && out_valid) |=> out_valid && $stable(out_result))
      else $error("result changed while stalled");

endmodule

### hdl/image_kernel_convolution_top.sv
// Top level of the square-kernel image convolution: registers, position counters, line RAM.
// Depends on ikc_pkg, ikc_ram and ikc_mac.
//
//   channel | ports                                   | handshake
//   req     | req_cmd req_coef_index req_coef_value   | req_valid / req_ready
//           | req_sample                              |
//   rsp     | rsp_result rsp_last                     | rsp_valid / rsp_ready
//   csr     | csr_index csr_data                      | csr_write, no wait
//
// One beat per cycle sustained while not stalled; a beat passes the input register with line
// RAM read, window, multiply and row sums; rsp_valid rises as it enters the output register.
// The pipeline advances as a whole; it stalls only while rsp_valid waits on rsp_ready.
// Reset is synchronous; it clears control state and restores register defaults.
// Line RAM and coefficient store come up undefined and need no clearing pass.
module image_kernel_convolution_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [ikc_pkg::CIDX_W-1:0]          req_coef_index,
   input  logic signed [ikc_pkg::COEF_W-1:0]   req_coef_value,
   input  logic signed [ikc_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ikc_pkg::RESULT_W-1:0] rsp_result,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [ikc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ikc_pkg::CSR_W-1:0]           csr_data
);
   import ikc_pkg::*;

   logic [1:0]        half_ff;
   logic [2:0]        chans_ff;
   logic [10:0]       width_ff;
   logic [10:0]       height_ff;
   shape_type         shape;
   logic [10:0]       width_c, height_c;
   logic [PCOL_W-1:0] pcols;
   logic [ROW_W-1:0]  prows;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              adv, accept;
   logic              produce, last;

   beat_type          s1_ff;
   sample_type        s1_sample_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              byp_ff;
   line_word_type     byp_data_ff;
   line_word_type     rd_data, lines, wr_data;
   logic              wr_en;
   column_type        column;

   // Clamp register values to their legal ranges.
   always_comb begin
      shape.half  = (int'(half_ff) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(half_ff);
      shape.chans = (chans_ff == '0) ? CHAN_W'(1) :
                    (int'(chans_ff) > MAX_CHANNELS) ? CHAN_W'(MAX_CHANNELS) : CHAN_W'(chans_ff);
      width_c  = (width_ff == '0) ? 11'd1 :
                 (int'(width_ff) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_ff;
      height_c = (height_ff == '0) ? 11'd1 :
                 (int'(height_ff) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : height_ff;
      pcols = PCOL_W'((int'(width_c) + 2 * int'(shape.half)) * int'(shape.chans));
      prows = ROW_W'(int'(height_c) + 2 * int'(shape.half));
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   always_comb begin
      produce = int'(row_ff) >= 2 * int'(shape.half) &&
                int'(col_ff) >= 2 * int'(shape.half) * int'(shape.chans);
      last    = (PCOL_W'(col_ff) == pcols - PCOL_W'(1)) && (row_ff == prows - ROW_W'(1));
      col_in  = col_ff;
      row_in  = row_ff;
      // Any known register restarts the image.
      if (csr_write && csr_index inside {REG_KERNEL_HALF, REG_CHANNEL_COUNT,
                                         REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT}) begin
         col_in = '0;
         row_in = '0;
      end else if (accept && req_cmd == CMD_SAMPLE) begin
         if (PCOL_W'(col_ff) == pcols - PCOL_W'(1)) begin
            col_in = '0;
            row_in = (row_ff == prows - ROW_W'(1)) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff   <= 2'd1;
         chans_ff  <= 3'd1;
         width_ff  <= 11'(MAX_WIDTH);
         height_ff <= 11'(MAX_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
         s1_ff.valid <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_write) begin
            case (csr_index)
               REG_KERNEL_HALF:   half_ff   <= csr_data[1:0];
               REG_CHANNEL_COUNT: chans_ff  <= csr_data[2:0];
               REG_IMAGE_WIDTH:   width_ff  <= csr_data[10:0];
               REG_IMAGE_HEIGHT:  height_ff <= csr_data[10:0];
               default: ;
            endcase
         end
         if (adv) begin
            s1_ff.valid      <= accept;
            s1_ff.cmd        <= cmd_type'(req_cmd);
            s1_ff.produce    <= produce;
            s1_ff.last       <= last;
            s1_ff.coef_index <= req_coef_index;
            s1_ff.coef_value <= req_coef_value;
            // Forward the word being written when the read hits the same column.
            byp_ff <= wr_en && s1_col_ff == col_ff;
         end
      end
      if (adv) begin
         s1_sample_ff <= req_sample;
         s1_col_ff    <= col_ff;
         byp_data_ff  <= wr_data;
      end
   end

   assign lines = byp_ff ? byp_data_ff : rd_data;
   assign wr_en = adv && s1_ff.valid && s1_ff.cmd == CMD_SAMPLE;

   always_comb begin
      column[0] = s1_sample_ff;
      for (int m = 0; m < KMAX - 1; m++) begin
         column[m+1] = lines[m];
      end
      wr_data[0] = s1_sample_ff;
      for (int m = 1; m < KMAX - 1; m++) begin
         wr_data[m] = lines[m-1];
      end
   end

   ikc_ram #(
      .WIDTH ($bits(line_word_type)),
      .DEPTH (LINE_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (adv),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   ikc_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .enable     (adv),
      .shape      (shape),
      .beat       (s1_ff),
      .column     (column),
      .out_valid  (rsp_valid),
      .out_result (rsp_result),
      .out_last   (rsp_last)
   );

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_write) |-> PCOL_W'(col_ff) < pcols)
      else $error("column position beyond padded row");
   a_bypass_source: assert property (@(posedge clock) disable iff (reset)
      $rose(byp_ff) |-> $past(wr_en))
      else $error("bypass without a write behind it");
   a_reset_home: assert property (@(posedge clock)
      reset |=> col_ff == '0 && row_ff == '0)
      else $error("positions not cleared by reset");
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && s1_ff.last && s1_ff.cmd == CMD_SAMPLE |-> s1_ff.produce)
      else $error("image end flagged on a warm-up sample");

endmodule
